// File: hw/rtl/vct_pkg.sv
// Shared types, constants and helper functions for the view camera transform.
// Used by every module of the block; depends on nothing else.
package vct_pkg;

	localparam int COORD_W = 32;
	localparam int ZOOM_W = 24;
	localparam int VIEW_W = 14;
	localparam int CFG_W = 24;
	localparam int DIV_DW = 40;
	localparam int DIV_NW = 57;
	localparam int CS_W = 33;
	localparam int VEC_W = 36;
	localparam int PROD_W = 69;
	localparam int ACC_W = 70;
	localparam int WIDE_W = 72;
	localparam int CORDIC_STEPS = 20;

	localparam logic [ZOOM_W-1:0] ZOOM_ONE = 24'd65536;
	localparam logic [VIEW_W-1:0] VIEW_W_RESET = 14'd1920;
	localparam logic [VIEW_W-1:0] VIEW_H_RESET = 14'd1080;
	localparam logic [ZOOM_W-1:0] MIN_ZOOM_RESET = 24'd6554;
	localparam logic [ZOOM_W-1:0] MAX_ZOOM_RESET = 24'd6553600;
	localparam logic signed [CS_W-1:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic [1:0] REG_VIEW_W = 2'd0;
	localparam logic [1:0] REG_VIEW_H = 2'd1;
	localparam logic [1:0] REG_MIN_ZOOM = 2'd2;
	localparam logic [1:0] REG_MAX_ZOOM = 2'd3;

	typedef enum logic [2:0] {
		OP_TO_WORLD = 3'd0,
		OP_TO_SCREEN = 3'd1,
		OP_PAN = 3'd2,
		OP_ZOOM_AT = 3'd3,
		OP_ROTATE_AT = 3'd4,
		OP_SET_ZOOM = 3'd5,
		OP_RESET = 3'd6,
		OP_BOUNDS = 3'd7
	} op_t;

	typedef enum logic [5:0] {
		CMD_NONE, CMD_LOAD, CMD_DIFF, CMD_DIV_X, CMD_TAKE_X, CMD_DIV_Y, CMD_TAKE_Y,
		CMD_CS, CMD_M0, CMD_M1, CMD_M2, CMD_M3, CMD_M4, CMD_M5, CMD_WORLD, CMD_PAN,
		CMD_SAVE_W, CMD_REFIT, CMD_BOUND, CMD_ZMUL, CMD_ZSET, CMD_ANG, CMD_Z0, CMD_Z1,
		CMD_Z2, CMD_SETZ, CMD_RCAM, CMD_CAM_RES, CMD_PUSH
	} dp_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DIFF, ST_DIV_X, ST_WAIT_X, ST_DIV_Y, ST_WAIT_Y, ST_CS, ST_WAIT_CS,
		ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_POST, ST_ZMUL, ST_ZSET, ST_ANG,
		ST_Z0, ST_Z1, ST_Z2, ST_SETZ, ST_RCAM, ST_FIN_CAM, ST_OUT
	} ctl_state_t;

	typedef struct packed {
		dp_cmd_t code;
		logic raw;
		logic neg_ang;
		logic corner_sel;
		logic [1:0] corner;
	} dp_ctl_t;

	typedef struct packed {
		logic div_done;
		logic cs_done;
	} dp_stat_t;

	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'd536870912;
			5'd1: v = 30'd316933406;
			5'd2: v = 30'd167458907;
			5'd3: v = 30'd85004756;
			5'd4: v = 30'd42667331;
			5'd5: v = 30'd21354465;
			5'd6: v = 30'd10679838;
			5'd7: v = 30'd5340245;
			5'd8: v = 30'd2670163;
			5'd9: v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > 72'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -72'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/view_camera_transform_core.sv
// Top level of the 2D view camera transform: controller plus datapath.
// Depends on vct_pkg, vct_ctrl and vct_dp.
//
// Each request on the input channel carries one operation (op) with a point
// or delta and an amount; exactly one result leaves on the output channel.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. The configuration port writes a register at every clock
// edge with cfg_we high; write it only while the block is idle.
// One request is worked at a time. A screen-offset evaluation runs two
// divisions by the zoom at one quotient bit per cycle (ending early when
// the quotient saturates), a 20-step CORDIC and six multiplier steps.
// To-screen needs no division, and bounds maps all four corners of the view.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls with a result still pending, the
// following result waits inside the block and input stall stays high.
// Reset clears the camera to position zero, zoom one and angle zero, and
// loads the register defaults.
module view_camera_transform_core #(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         op,
	input  logic signed [vct_pkg::COORD_W-1:0] point_x,
	input  logic signed [vct_pkg::COORD_W-1:0] point_y,
	input  logic signed [vct_pkg::COORD_W-1:0] amount,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [vct_pkg::COORD_W-1:0] out_x,
	output logic signed [vct_pkg::COORD_W-1:0] out_y,
	output logic signed [vct_pkg::COORD_W-1:0] out_x2,
	output logic signed [vct_pkg::COORD_W-1:0] out_y2,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [vct_pkg::CFG_W-1:0]          cfg_data
);
	import vct_pkg::*;

	dp_ctl_t ctl;
	dp_stat_t stat;

	vct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.stat      (stat)
	);

	vct_dp #(
		.ANGLE_BITS      (ANGLE_BITS),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.point_x   (point_x),
		.point_y   (point_y),
		.amount    (amount),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_x2    (out_x2),
		.out_y2    (out_y2)
	);

endmodule

// File: hw/rtl/vct_div.sv
// Sequential divider for division by the zoom: one quotient bit per cycle,
// rounding to nearest and saturating to 32 bits. Depends on vct_pkg.
module vct_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [vct_pkg::DIV_DW-1:0] d,
	input  logic [vct_pkg::ZOOM_W-1:0]        z,
	output logic                              done,
	output logic signed [vct_pkg::COORD_W-1:0] q
);
	import vct_pkg::*;

	logic [ZOOM_W-1:0] z0;
	logic [DIV_DW-1:0] mag;
	logic [DIV_NW-1:0] num, lim;
	logic sat;
	logic [ZOOM_W-1:0] r_q, z_q;
	logic [30:0] nl_q, qa_q, qa_nxt;
	logic [4:0] cnt_q;
	logic busy_q, done_q, neg_q;
	logic signed [COORD_W-1:0] q_q;
	logic [ZOOM_W:0] t, rn;
	logic ge;

	always_comb begin
		z0 = (z == '0) ? ZOOM_W'(1) : z;
		mag = d[DIV_DW-1] ? DIV_DW'(-d) : DIV_DW'(d);
		num = DIV_NW'({mag, 16'b0}) + DIV_NW'(z0 >> 1);
		lim = DIV_NW'({z0, 31'b0});
		sat = (num >= lim);
		t = {r_q, nl_q[30]};
		ge = (t >= {1'b0, z_q});
		rn = ge ? (t - {1'b0, z_q}) : t;
		qa_nxt = {qa_q[29:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
			busy_q <= !sat;
			done_q <= sat;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd30) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= d[DIV_DW-1];
			z_q <= z0;
			r_q <= num[54:31];
			nl_q <= num[30:0];
			qa_q <= '0;
			if (sat) begin
				q_q <= d[DIV_DW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end
		end else if (busy_q) begin
			r_q <= rn[ZOOM_W-1:0];
			nl_q <= {nl_q[29:0], 1'b0};
			qa_q <= qa_nxt;
			if (cnt_q == 5'd30) begin
				q_q <= neg_q ? -signed'({1'b0, qa_nxt}) : signed'({1'b0, qa_nxt});
			end
		end
	end

	assign done = done_q;
	assign q = q_q;

endmodule

// File: hw/rtl/vct_cordic.sv
// Iterative CORDIC giving cosine and sine in Q2.30 for a binary angle,
// one micro-rotation per cycle. Depends on vct_pkg.
module vct_cordic #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ANGLE_BITS-1:0]          ang,
	output logic                           done,
	output logic signed [vct_pkg::CS_W-1:0] c,
	output logic signed [vct_pkg::CS_W-1:0] s
);
	import vct_pkg::*;

	logic [31:0] a32, a32p, zr;
	logic [1:0] quad;
	logic signed [CS_W-1:0] x_q, y_q, z_q, xs, ys, at;
	logic [1:0] quad_q;
	logic [4:0] i_q;
	logic busy_q, done_q;

	always_comb begin
		a32 = {ang, {(32-ANGLE_BITS){1'b0}}};
		a32p = a32 + 32'h2000_0000;
		quad = a32p[31:30];
		zr = a32 - {quad, 30'b0};
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = signed'({3'b0, atan_turn(i_q)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			i_q <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 5'd1;
			if (i_q == 5'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= CS_W'(signed'(zr));
			quad_q <= quad;
		end else if (busy_q) begin
			if (!z_q[CS_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		case (quad_q)
			2'd0: begin
				c = x_q;
				s = y_q;
			end
			2'd1: begin
				c = -y_q;
				s = x_q;
			end
			2'd2: begin
				c = -x_q;
				s = -y_q;
			end
			default: begin
				c = y_q;
				s = -x_q;
			end
		endcase
	end

	assign done = done_q;

endmodule

// File: hw/rtl/vct_ctrl.sv
// Controller state machine that sequences each request through the datapath.
// Depends on vct_pkg for states, commands and status.
module vct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	output logic               out_valid,
	input  logic               out_stall,
	output vct_pkg::dp_ctl_t   ctl,
	input  vct_pkg::dp_stat_t  stat
);
	import vct_pkg::*;

	ctl_state_t state_q, state_nxt;
	op_t op_q, op_nxt;
	logic [1:0] k_q, k_nxt;
	logic out_valid_q;
	logic push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_TO_WORLD;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			op_q <= op_nxt;
			k_q <= k_nxt;
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		op_nxt = op_q;
		k_nxt = k_q;
		push = 1'b0;
		ctl.code = CMD_NONE;
		ctl.raw = (op_q == OP_PAN);
		ctl.neg_ang = (op_q == OP_TO_SCREEN);
		ctl.corner_sel = (op_q == OP_BOUNDS);
		ctl.corner = k_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.code = CMD_LOAD;
					op_nxt = op_t'(op);
					k_nxt = '0;
					case (op_t'(op))
						OP_TO_SCREEN: state_nxt = ST_DIFF;
						OP_SET_ZOOM: state_nxt = ST_SETZ;
						OP_RESET: state_nxt = ST_RCAM;
						default: state_nxt = ST_DIV_X;
					endcase
				end
			end
			ST_DIFF: begin
				ctl.code = CMD_DIFF;
				state_nxt = ST_CS;
			end
			ST_DIV_X: begin
				ctl.code = CMD_DIV_X;
				state_nxt = ST_WAIT_X;
			end
			ST_WAIT_X: begin
				if (stat.div_done) begin
					ctl.code = CMD_TAKE_X;
					state_nxt = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				ctl.code = CMD_DIV_Y;
				state_nxt = ST_WAIT_Y;
			end
			ST_WAIT_Y: begin
				if (stat.div_done) begin
					ctl.code = CMD_TAKE_Y;
					state_nxt = ST_CS;
				end
			end
			ST_CS: begin
				ctl.code = CMD_CS;
				state_nxt = ST_WAIT_CS;
			end
			ST_WAIT_CS: begin
				if (stat.cs_done) begin
					state_nxt = ST_M0;
				end
			end
			ST_M0: begin
				ctl.code = CMD_M0;
				state_nxt = ST_M1;
			end
			ST_M1: begin
				ctl.code = CMD_M1;
				state_nxt = ST_M2;
			end
			ST_M2: begin
				ctl.code = CMD_M2;
				state_nxt = ST_M3;
			end
			ST_M3: begin
				ctl.code = CMD_M3;
				state_nxt = ST_M4;
			end
			ST_M4: begin
				ctl.code = CMD_M4;
				state_nxt = ST_M5;
			end
			ST_M5: begin
				ctl.code = CMD_M5;
				state_nxt = ST_POST;
			end
			ST_POST: begin
				case (op_q)
					OP_TO_WORLD: begin
						ctl.code = CMD_WORLD;
						state_nxt = ST_OUT;
					end
					OP_TO_SCREEN: state_nxt = ST_Z0;
					OP_PAN: begin
						ctl.code = CMD_PAN;
						state_nxt = ST_FIN_CAM;
					end
					OP_ZOOM_AT, OP_ROTATE_AT: begin
						if (k_q == 2'd0) begin
							ctl.code = CMD_SAVE_W;
							state_nxt = (op_q == OP_ZOOM_AT) ? ST_ZMUL : ST_ANG;
						end else begin
							ctl.code = CMD_REFIT;
							state_nxt = ST_FIN_CAM;
						end
					end
					OP_BOUNDS: begin
						ctl.code = CMD_BOUND;
						if (k_q == 2'd3) begin
							state_nxt = ST_OUT;
						end else begin
							k_nxt = k_q + 2'd1;
							state_nxt = ST_DIV_X;
						end
					end
					default: state_nxt = ST_OUT;
				endcase
			end
			ST_ZMUL: begin
				ctl.code = CMD_ZMUL;
				state_nxt = ST_ZSET;
			end
			ST_ZSET: begin
				ctl.code = CMD_ZSET;
				k_nxt = 2'd1;
				state_nxt = ST_DIV_X;
			end
			ST_ANG: begin
				ctl.code = CMD_ANG;
				k_nxt = 2'd1;
				state_nxt = ST_DIV_X;
			end
			ST_Z0: begin
				ctl.code = CMD_Z0;
				state_nxt = ST_Z1;
			end
			ST_Z1: begin
				ctl.code = CMD_Z1;
				state_nxt = ST_Z2;
			end
			ST_Z2: begin
				ctl.code = CMD_Z2;
				state_nxt = ST_OUT;
			end
			ST_SETZ: begin
				ctl.code = CMD_SETZ;
				state_nxt = ST_FIN_CAM;
			end
			ST_RCAM: begin
				ctl.code = CMD_RCAM;
				state_nxt = ST_FIN_CAM;
			end
			ST_FIN_CAM: begin
				ctl.code = CMD_CAM_RES;
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || !out_stall) begin
					ctl.code = CMD_PUSH;
					push = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("request accepted but controller stayed idle");

	a_rotate_after_cs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_M0) |-> stat.cs_done)
		else $error("rotation started before sine and cosine were ready");

	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output state");

endmodule

// File: hw/rtl/vct_dp.sv
// Datapath: camera state, configuration registers, the shared multiplier,
// the zoom divider and the CORDIC unit. Depends on vct_pkg, vct_div, vct_cordic.
module vct_dp #(
	parameter int ANGLE_BITS = 16,
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  vct_pkg::dp_ctl_t                   ctl,
	output vct_pkg::dp_stat_t                  stat,
	input  logic signed [vct_pkg::COORD_W-1:0] point_x,
	input  logic signed [vct_pkg::COORD_W-1:0] point_y,
	input  logic signed [vct_pkg::COORD_W-1:0] amount,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [vct_pkg::CFG_W-1:0]          cfg_data,
	output logic signed [vct_pkg::COORD_W-1:0] out_x,
	output logic signed [vct_pkg::COORD_W-1:0] out_y,
	output logic signed [vct_pkg::COORD_W-1:0] out_x2,
	output logic signed [vct_pkg::COORD_W-1:0] out_y2
);
	import vct_pkg::*;

	localparam int HSH = COORD_FRAC_BITS - 1;

	logic [VIEW_W-1:0] vw_q, vh_q, vw_eff, vh_eff;
	logic [ZOOM_W-1:0] min_q, max_q, zoom_q;
	logic signed [COORD_W-1:0] cam_x_q, cam_y_q, px_q, py_q, amt_q, wx_q, wy_q;
	logic [ANGLE_BITS-1:0] ang_q, cs_ang;
	logic signed [VEC_W-1:0] vx_q, vy_q, tx_q;
	logic signed [PROD_W-1:0] prod_q, mul_a, mul_b, prod_rnd;
	logic signed [ACC_W-1:0] acc_q, acc_rnd;
	logic signed [52:0] pr16;
	logic signed [DIV_DW-1:0] hw, hh, div_d;
	logic signed [COORD_W-1:0] div_q, res_x_q, res_y_q, res_x2_q, res_y2_q;
	logic signed [CS_W-1:0] cs_c, cs_s;
	logic signed [COORD_W-1:0] wld_x, wld_y;
	logic div_start, div_done, cs_start, cs_done, mul_en, first;

	function automatic logic [ZOOM_W-1:0] clamp_zoom(input logic signed [52:0] z,
			input logic [ZOOM_W-1:0] mn, input logic [ZOOM_W-1:0] mx);
		logic signed [52:0] t;
		t = z;
		if (t > signed'({29'b0, mx})) begin
			t = signed'({29'b0, mx});
		end
		if (t < signed'({29'b0, mn})) begin
			t = signed'({29'b0, mn});
		end
		return t[ZOOM_W-1:0];
	endfunction

	always_comb begin
		vw_eff = (vw_q == '0) ? VIEW_W'(1) : vw_q;
		vh_eff = (vh_q == '0) ? VIEW_W'(1) : vh_q;
		hw = signed'(DIV_DW'(vw_eff) << HSH);
		hh = signed'(DIV_DW'(vh_eff) << HSH);
		if (ctl.code == CMD_DIV_Y) begin
			if (ctl.corner_sel) begin
				div_d = ctl.corner[1] ? hh : -hh;
			end else if (ctl.raw) begin
				div_d = DIV_DW'(py_q);
			end else begin
				div_d = DIV_DW'(py_q) - hh;
			end
		end else begin
			if (ctl.corner_sel) begin
				div_d = ctl.corner[0] ? hw : -hw;
			end else if (ctl.raw) begin
				div_d = DIV_DW'(px_q);
			end else begin
				div_d = DIV_DW'(px_q) - hw;
			end
		end
		div_start = (ctl.code == CMD_DIV_X) || (ctl.code == CMD_DIV_Y);
		cs_start = (ctl.code == CMD_CS);
		cs_ang = ctl.neg_ang ? (ANGLE_BITS'(0) - ang_q) : ang_q;
	end

	vct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.d      (div_d),
		.z      (zoom_q),
		.done   (div_done),
		.q      (div_q)
	);

	vct_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cs_start),
		.ang    (cs_ang),
		.done   (cs_done),
		.c      (cs_c),
		.s      (cs_s)
	);

	assign stat.div_done = div_done;
	assign stat.cs_done = cs_done;

	always_comb begin
		mul_en = 1'b1;
		mul_a = PROD_W'(vx_q);
		mul_b = PROD_W'(cs_c);
		case (ctl.code)
			CMD_M0: begin
				mul_a = PROD_W'(vx_q);
				mul_b = PROD_W'(cs_c);
			end
			CMD_M1: begin
				mul_a = PROD_W'(vy_q);
				mul_b = PROD_W'(cs_s);
			end
			CMD_M2: begin
				mul_a = PROD_W'(vx_q);
				mul_b = PROD_W'(cs_s);
			end
			CMD_M3: begin
				mul_a = PROD_W'(vy_q);
				mul_b = PROD_W'(cs_c);
			end
			CMD_Z0: begin
				mul_a = PROD_W'(vx_q);
				mul_b = PROD_W'(signed'({1'b0, zoom_q}));
			end
			CMD_Z1: begin
				mul_a = PROD_W'(vy_q);
				mul_b = PROD_W'(signed'({1'b0, zoom_q}));
			end
			CMD_ZMUL: begin
				mul_a = PROD_W'(signed'({1'b0, zoom_q}));
				mul_b = PROD_W'(amt_q);
			end
			default: mul_en = 1'b0;
		endcase
		acc_rnd = acc_q + 70'sd536870912;
		prod_rnd = prod_q + 69'sd32768;
		pr16 = signed'(prod_rnd[PROD_W-1:16]);
		wld_x = sat32(WIDE_W'(cam_x_q) + WIDE_W'(vx_q));
		wld_y = sat32(WIDE_W'(cam_y_q) + WIDE_W'(vy_q));
		first = (ctl.corner == 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vw_q <= VIEW_W_RESET;
			vh_q <= VIEW_H_RESET;
			min_q <= MIN_ZOOM_RESET;
			max_q <= MAX_ZOOM_RESET;
			cam_x_q <= '0;
			cam_y_q <= '0;
			zoom_q <= ZOOM_ONE;
			ang_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_VIEW_W: vw_q <= cfg_data[VIEW_W-1:0];
					REG_VIEW_H: vh_q <= cfg_data[VIEW_W-1:0];
					REG_MIN_ZOOM: min_q <= cfg_data[ZOOM_W-1:0];
					REG_MAX_ZOOM: max_q <= cfg_data[ZOOM_W-1:0];
					default: ;
				endcase
			end
			case (ctl.code)
				CMD_PAN: begin
					cam_x_q <= sat32(WIDE_W'(cam_x_q) - WIDE_W'(vx_q));
					cam_y_q <= sat32(WIDE_W'(cam_y_q) - WIDE_W'(vy_q));
				end
				CMD_REFIT: begin
					cam_x_q <= sat32(WIDE_W'(wx_q) - WIDE_W'(vx_q));
					cam_y_q <= sat32(WIDE_W'(wy_q) - WIDE_W'(vy_q));
				end
				CMD_ZSET: zoom_q <= clamp_zoom(pr16, min_q, max_q);
				CMD_SETZ: zoom_q <= clamp_zoom(53'(amt_q), min_q, max_q);
				CMD_ANG: ang_q <= ang_q + amt_q[ANGLE_BITS-1:0];
				CMD_RCAM: begin
					cam_x_q <= px_q;
					cam_y_q <= py_q;
					zoom_q <= ZOOM_ONE;
					ang_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (ctl.code)
			CMD_LOAD: begin
				px_q <= point_x;
				py_q <= point_y;
				amt_q <= amount;
			end
			CMD_DIFF: begin
				vx_q <= VEC_W'(sat32(WIDE_W'(px_q) - WIDE_W'(cam_x_q)));
				vy_q <= VEC_W'(sat32(WIDE_W'(py_q) - WIDE_W'(cam_y_q)));
			end
			CMD_TAKE_X: vx_q <= VEC_W'(div_q);
			CMD_TAKE_Y: vy_q <= VEC_W'(div_q);
			CMD_M1: acc_q <= ACC_W'(prod_q);
			CMD_M2: acc_q <= acc_q - ACC_W'(prod_q);
			CMD_M3: begin
				tx_q <= acc_rnd[65:30];
				acc_q <= ACC_W'(prod_q);
			end
			CMD_M4: acc_q <= acc_q + ACC_W'(prod_q);
			CMD_M5: begin
				vx_q <= tx_q;
				vy_q <= acc_rnd[65:30];
			end
			CMD_WORLD: begin
				res_x_q <= wld_x;
				res_y_q <= wld_y;
				res_x2_q <= '0;
				res_y2_q <= '0;
			end
			CMD_SAVE_W: begin
				wx_q <= wld_x;
				wy_q <= wld_y;
			end
			CMD_BOUND: begin
				if (first || wld_x < res_x_q) res_x_q <= wld_x;
				if (first || wld_y < res_y_q) res_y_q <= wld_y;
				if (first || wld_x > res_x2_q) res_x2_q <= wld_x;
				if (first || wld_y > res_y2_q) res_y2_q <= wld_y;
			end
			CMD_Z1: res_x_q <= sat32(WIDE_W'(hw) + WIDE_W'(pr16));
			CMD_Z2: begin
				res_y_q <= sat32(WIDE_W'(hh) + WIDE_W'(pr16));
				res_x2_q <= '0;
				res_y2_q <= '0;
			end
			CMD_CAM_RES: begin
				res_x_q <= cam_x_q;
				res_y_q <= cam_y_q;
				res_x2_q <= '0;
				res_y2_q <= '0;
			end
			CMD_PUSH: begin
				out_x <= res_x_q;
				out_y <= res_y_q;
				out_x2 <= res_x2_q;
				out_y2 <= res_y2_q;
			end
			default: ;
		endcase
	end

endmodule
